FILE: rtl/u8cp_pkg.sv
// Shared types and constants for the UTF-8 to code point decoder.
package u8cp_pkg;

    // Result status codes.
    localparam logic [1:0] ST_CHAR  = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    // Code point limits, all at the width of the accumulator.
    localparam logic [30:0] SUPP_BASE = 31'h0001_0000;
    localparam logic [30:0] HIGH_LO   = 31'h0000_d800;
    localparam logic [30:0] HIGH_HI   = 31'h0000_dbff;
    localparam logic [30:0] LOW_LO    = 31'h0000_dc00;
    localparam logic [30:0] LOW_HI    = 31'h0000_dfff;
    localparam logic [30:0] MIN_TWO   = 31'h0000_0080;
    localparam logic [30:0] MIN_THREE = 31'h0000_0800;
    localparam logic [30:0] MIN_FIVE  = 31'h0020_0000;
    localparam logic [30:0] MIN_SIX   = 31'h0400_0000;

    // Pairing phases.
    localparam logic [1:0] PH_NONE   = 2'd0;
    localparam logic [1:0] PH_LEAD   = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    // Input item.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [30:0] code_point;
        logic [1:0]  status;
        logic        end_of_string;
    } t_out;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [30:0] acc;
        logic [2:0]  rem;
        logic [2:0]  len;
        logic [9:0]  high;
        logic [1:0]  phase;
        logic        drop;
    } t_state;

    // Outcome of one byte.
    typedef enum logic [1:0] {
        TK_PEND,
        TK_CHAR,
        TK_ERR,
        TK_END
    } t_take;

endpackage

FILE: rtl/u8cp_step.sv
// Combinational per-byte decode: next state and optional result.
module u8cp_step (
    input  u8cp_pkg::t_state i_state,
    input  u8cp_pkg::t_in    i_in,
    output u8cp_pkg::t_state o_state,
    output logic             o_emit,
    output u8cp_pkg::t_out   o_result
);
    import u8cp_pkg::*;

    t_state      ns;
    t_take       take;
    logic [30:0] cp;
    logic [30:0] w;
    logic [2:0]  rem_dec;
    logic [7:0]  b;

    assign b       = i_in.byte_in;
    assign w       = {i_state.acc[24:0], b[5:0]};
    assign rem_dec = i_state.rem - 3'd1;

    always_comb begin
        ns   = i_state;
        take = TK_PEND;
        cp   = '0;
        if (b == 8'd0) begin
            take = TK_END;
        end else if (i_state.rem == 3'd0) begin
            if (i_state.phase == PH_LEAD) begin
                // Only a three-byte lead may open the low half of a pair.
                if (b < 8'he0 || b > 8'hef) begin
                    take = TK_ERR;
                end else begin
                    ns.acc   = {27'd0, b[3:0]};
                    ns.rem   = 3'd2;
                    ns.len   = 3'd3;
                    ns.phase = PH_SECOND;
                end
            end else if (b <= 8'h7f) begin
                take = TK_CHAR;
                cp   = {23'd0, b};
            end else if (b <= 8'hbf) begin
                take = TK_ERR;
            end else if (b <= 8'hdf) begin
                ns.acc = {26'd0, b[4:0]};
                ns.len = 3'd2;
                ns.rem = 3'd1;
            end else if (b <= 8'hef) begin
                ns.acc = {27'd0, b[3:0]};
                ns.len = 3'd3;
                ns.rem = 3'd2;
            end else if (b <= 8'hf7) begin
                ns.acc = {28'd0, b[2:0]};
                ns.len = 3'd4;
                ns.rem = 3'd3;
            end else if (b <= 8'hfb) begin
                ns.acc = {29'd0, b[1:0]};
                ns.len = 3'd5;
                ns.rem = 3'd4;
            end else if (b <= 8'hfd) begin
                ns.acc = {30'd0, b[0]};
                ns.len = 3'd6;
                ns.rem = 3'd5;
            end else begin
                take = TK_ERR;
            end
        end else if (b < 8'h80 || b > 8'hbf) begin
            take = TK_ERR;
        end else if (rem_dec != 3'd0) begin
            ns.acc = w;
            ns.rem = rem_dec;
        end else begin
            // Final continuation byte: check the finished value.
            ns.acc = '0;
            ns.rem = 3'd0;
            if (i_state.phase == PH_SECOND) begin
                ns.phase = PH_NONE;
                if (w < LOW_LO || w > LOW_HI) begin
                    take = TK_ERR;
                end else begin
                    take    = TK_CHAR;
                    cp      = SUPP_BASE + {11'd0, i_state.high, 10'd0} + {21'd0, w[9:0]};
                    ns.high = '0;
                end
            end else begin
                take = TK_CHAR;
                cp   = w;
                case (i_state.len)
                    3'd2: begin
                        if (w < MIN_TWO) take = TK_ERR;
                    end
                    3'd3: begin
                        if (w >= HIGH_LO && w <= HIGH_HI) begin
                            // High surrogate: hold it and wait for its partner.
                            take     = TK_PEND;
                            ns.high  = w[9:0];
                            ns.phase = PH_LEAD;
                        end else if (w < MIN_THREE || (w >= LOW_LO && w <= LOW_HI)) begin
                            take = TK_ERR;
                        end
                    end
                    3'd4: begin
                        if (w < SUPP_BASE) take = TK_ERR;
                    end
                    3'd5: begin
                        if (w < MIN_FIVE) take = TK_ERR;
                    end
                    default: begin
                        if (w < MIN_SIX) take = TK_ERR;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_state                 = ns;
        o_emit                  = 1'b0;
        o_result.code_point     = '0;
        o_result.status         = ST_END;
        o_result.end_of_string  = i_in.last_byte;
        if (i_state.drop) begin
            // Bytes after an error or terminator are discarded.
            o_state = i_state;
            if (i_in.last_byte) begin
                o_emit  = 1'b1;
                o_state = '0;
            end
        end else begin
            if (take != TK_PEND || i_in.last_byte) begin
                o_emit = 1'b1;
            end
            case (take)
                TK_CHAR: begin
                    o_result.status     = ST_CHAR;
                    o_result.code_point = cp;
                end
                TK_ERR: begin
                    o_result.status = ST_ERROR;
                end
                default: begin
                    o_result.status = ST_END;
                end
            endcase
            if (i_in.last_byte) begin
                o_state = '0;
            end else if (take == TK_ERR || take == TK_END) begin
                o_state      = '0;
                o_state.drop = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/u8cp_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
module u8cp_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  u8cp_pkg::t_out i_data,
    input  logic           i_stall,
    output logic           o_valid,
    output u8cp_pkg::t_out o_data,
    output logic           o_free
);
    import u8cp_pkg::*;

    logic r_valid;
    t_out r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    // The register can take a new result when empty or being drained.
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/utf8_to_codepoint_decoder_unit.sv
// Top level of the UTF-8 byte stream to code point decoder.
// This block takes one byte of a UTF-8 string per transfer and delivers at most one
// result per byte: a code point (status 0), an encoding error (status 1) or an end of
// string without a character (status 2). Sequences of one to six bytes are decoded,
// overlong forms, stray continuation bytes and the bytes FE and FF are errors, and a
// three-byte high surrogate followed by a three-byte low surrogate is joined into one
// supplementary code point. A zero byte or an error makes the block discard the rest
// of the string; the byte marked last always yields exactly one result with
// end_of_string set, and leaves the decoder cleared for the next string. The block
// accepts one byte per clock cycle unless the output stalls. A byte is held in the
// input register, is decoded by short compare and shift logic against the carried
// state, and its result lands in the output register, which presents it on the output.
// The output register alone sets the throughput: while it holds a result that the
// consumer stalls, the decode stage and then the input stage hold as well.
module utf8_to_codepoint_decoder_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  u8cp_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output u8cp_pkg::t_out o_out_data,
    input  logic           i_out_stall
);
    import u8cp_pkg::*;

    // Input register.
    logic   r_in_valid;
    t_in    r_in;

    // Decoder state carried between bytes.
    t_state r_state;
    t_state n_state;

    logic   step_emit;
    t_out   step_result;
    logic   out_free;
    logic   adv;
    logic   in_free;

    // The decode stage advances when it holds a byte and the result register can
    // take whatever that byte produces. Bytes that produce nothing still wait, which
    // keeps results in byte order without extra buffering.
    assign adv     = r_in_valid && out_free;
    assign in_free = !r_in_valid || adv;
    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    u8cp_step u_step (
        .i_state  (r_state),
        .i_in     (r_in),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // State only moves when a byte is actually consumed by the decode stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    u8cp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && step_emit),
        .i_data  (step_result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_free  (out_free)
    );

    // A byte marked last always leaves a result with end_of_string set.
    a_last_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.last_byte |=> o_out_valid && o_out_data.end_of_string)
        else $error("last byte did not produce an end-of-string result");

    // The decoder is fully cleared after the last byte of a string.
    a_last_clears_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.last_byte |=> r_state == '0)
        else $error("decoder state not cleared after last byte");

    // While discarding, no sequence or pairing may be open.
    a_drop_is_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.drop |-> r_state.rem == 3'd0 && r_state.phase == PH_NONE)
        else $error("open sequence while discarding bytes");

    // Only character results carry a nonzero code point.
    a_cp_only_for_char : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_CHAR |-> o_out_data.code_point == '0)
        else $error("code point on a non-character result");

endmodule
